// ----- sv/fdm_pkg.sv -----
`default_nettype none
package fdm_pkg;

   // sample format
   localparam int SAMPLE_W = 16;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_MIX = 8'd2;

   // register limits and reset values
   localparam int DELAY_W = 17;
   localparam int GAIN_W  = 16;
   localparam int MIX_W   = 17;
   localparam int DELAY_RESET_VAL = 13230;
   localparam logic [GAIN_W-1:0] FB_MAX   = 16'd62259;
   localparam logic [MIX_W-1:0]  MIX_FULL = 17'd65536;

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // one result leaving the arithmetic pipeline
   typedef struct packed {
      logic       valid;
      sample_type sample;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/fdm_store.sv -----
`default_nettype none
module fdm_store import fdm_pkg::*; #(
   parameter int STORE_DEPTH = 131072,
   parameter int AW = 17
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output      sample_type    rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire sample_type    wr_data
);

   sample_type mem [STORE_DEPTH];
   sample_type rd_data_ff;

   // one write port, one registered read port, read sees old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/fdm_mac.sv -----
`default_nettype none
module fdm_mac import fdm_pkg::*; #(
   parameter int AW = 17
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // item whose store read has just returned
   input  wire logic              s1_valid,
   input  wire sample_type        s1_x,
   input  wire logic [AW-1:0]     s1_wp,
   input  wire logic [AW-1:0]     s1_rd,
   input  wire logic              s1_written,
   input  wire sample_type        rd_data,
   // gains
   input  wire logic [GAIN_W-1:0] fb_gain,
   input  wire logic [MIX_W-1:0]  wet_gain,
   input  wire logic [MIX_W-1:0]  dry_gain,
   // store write back
   output      logic              wr_en,
   output      logic [AW-1:0]     wr_addr,
   output      sample_type        wr_data,
   // result and occupancy
   output      rsp_type           rsp,
   output      logic              s2_valid
);

   function automatic sample_type sat16(input logic signed [18:0] v);
      sample_type r;
      if (v > 19'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // stage 1: select the delayed sample
   logic                byp_valid_ff;
   logic [AW-1:0]       byp_addr_ff;
   sample_type          byp_data_ff;
   sample_type          delayed;

   always_comb begin
      if (byp_valid_ff && (byp_addr_ff == s1_rd)) begin
         delayed = byp_data_ff;
      end else if (s1_written) begin
         delayed = rd_data;
      end else begin
         delayed = '0;
      end
   end

   // stage 1: products
   logic signed [GAIN_W:0]   fb_s;
   logic signed [MIX_W:0]    wet_s;
   logic signed [MIX_W:0]    dry_s;
   logic signed [32:0]       fbprod_in;
   logic signed [33:0]       wetprod_in;
   logic signed [33:0]       dryprod_in;

   assign fb_s       = signed'({1'b0, fb_gain});
   assign wet_s      = signed'({1'b0, wet_gain});
   assign dry_s      = signed'({1'b0, dry_gain});
   assign fbprod_in  = delayed * fb_s;
   assign wetprod_in = delayed * wet_s;
   assign dryprod_in = s1_x * dry_s;

   // stage 2 registers
   logic                s2_valid_ff;
   sample_type          s2_x_ff;
   logic [AW-1:0]       s2_wp_ff;
   logic signed [32:0]  fbprod_ff;
   logic signed [33:0]  wetprod_ff;
   logic signed [33:0]  dryprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
      end
      s2_x_ff    <= s1_x;
      s2_wp_ff   <= s1_wp;
      fbprod_ff  <= fbprod_in;
      wetprod_ff <= wetprod_in;
      dryprod_ff <= dryprod_in;
   end

   // stage 2: feedback value to store, rounded half up and saturated
   logic signed [32:0]  fb_round;
   logic signed [18:0]  fb_sum;
   sample_type          stored;

   assign fb_round = fbprod_ff + 33'sd32768;
   assign fb_sum   = 19'(s2_x_ff) + 19'(signed'(fb_round[32:16]));
   assign stored   = sat16(fb_sum);

   // stage 2: dry/wet mix
   logic signed [34:0]  mix_acc;

   assign mix_acc = 35'(dryprod_ff) + 35'(wetprod_ff) + 35'sd32768;

   // bypass holds the write made at the edge the stage 1 read happened
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= s2_valid_ff;
      end
      byp_addr_ff <= s2_wp_ff;
      byp_data_ff <= stored;
   end

   assign wr_en      = s2_valid_ff;
   assign wr_addr    = s2_wp_ff;
   assign wr_data    = stored;
   assign rsp.valid  = s2_valid_ff;
   assign rsp.sample = sat16(mix_acc[34:16]);
   assign s2_valid   = s2_valid_ff;

endmodule
`default_nettype wire

// ----- sv/fdm_rsp_queue.sv -----
`default_nettype none
module fdm_rsp_queue import fdm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rsp_type           push,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [15:0]       rsp_tdata,    // [15:0] sample_out
   output      logic [QCNT_W-1:0] count
);

   sample_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff;
   logic [QPTR_W-1:0]   head_in;
   logic [QPTR_W-1:0]   tail_ff;
   logic [QPTR_W-1:0]   tail_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;

   assign pop = rsp_tvalid && rsp_tready;

   // pointer and fill level update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = head_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
      if (push.valid) begin
         tail_in  = tail_ff + 1'b1;
         count_in = count_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[tail_ff] <= push.sample;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = entry_ff[head_ff];
   assign count      = count_ff;

endmodule
`default_nettype wire

// ----- sv/feedback_delay_line_mixer_top.sv -----
`default_nettype none
// Feedback echo on a stream of signed Q1.15 samples. Each word on req reads the
// sample delay_length positions behind the write pointer from a single
// STORE_DEPTH-entry store, writes sample_in plus the rounded feedback product back
// at the write pointer (saturated), and returns one rsp word: the rounded,
// saturated dry/wet mix of sample_in and the delayed sample. The block takes one
// word per clock while the queue has room and no read hazard stalls it. The
// store has one write and one registered read port, and the feedback value is
// written from stage 2, so a delay of one sample (the read lands on the entry
// the previous word is still computing) holds each word off while the previous
// one is in stage 1. A four-word result queue lets input continue while results
// wait. Reset needs no clearing pass: a wrap flag and the write pointer tell which
// entries have been written, and unwritten ones read as zero. Registers
// (csr_index): 0 delay_length, clamped to STORE_DEPTH-1; 1 feedback_gain, clamped
// to 62259; 2 wet_mix, clamped to 65536. Write them only while the block is idle.
module feedback_delay_line_mixer_top import fdm_pkg::*; #(
   parameter int STORE_DEPTH = 131072
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input samples
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [15:0]            req_tdata,    // [15:0] sample_in
   // mixed samples
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [15:0]            rsp_tdata,    // [15:0] sample_out
   // register writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int DW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
   localparam logic [AW-1:0] DELAY_RESET =
      (DELAY_RESET_VAL >= STORE_DEPTH) ? AW'(STORE_DEPTH - 1) : AW'(DELAY_RESET_VAL);

   // configuration registers, clamped on write
   logic [AW-1:0]     delay_ff;
   logic [AW-1:0]     delay_in;
   logic [GAIN_W-1:0] fb_ff;
   logic [GAIN_W-1:0] fb_in;
   logic [MIX_W-1:0]  wet_ff;
   logic [MIX_W-1:0]  wet_in;
   logic [MIX_W-1:0]  dry_ff;
   logic [MIX_W-1:0]  dry_in;
   logic [DW-1:0]     csr_delay;

   assign csr_ready = 1'b1;
   assign csr_delay = DW'(csr_data[DELAY_W-1:0]);

   always_comb begin
      delay_in = delay_ff;
      fb_in    = fb_ff;
      wet_in   = wet_ff;
      dry_in   = dry_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DELAY_LENGTH: begin
               if (csr_delay >= DW'(STORE_DEPTH)) begin
                  delay_in = LAST_ADDR;
               end else begin
                  delay_in = AW'(csr_delay);
               end
            end
            REG_FEEDBACK_GAIN: begin
               if (csr_data[GAIN_W-1:0] > FB_MAX) begin
                  fb_in = FB_MAX;
               end else begin
                  fb_in = csr_data[GAIN_W-1:0];
               end
            end
            REG_WET_MIX: begin
               if (csr_data[MIX_W-1:0] > MIX_FULL) begin
                  wet_in = MIX_FULL;
               end else begin
                  wet_in = csr_data[MIX_W-1:0];
               end
               dry_in = MIX_FULL - wet_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         fb_ff    <= '0;
         wet_ff   <= '0;
         dry_ff   <= MIX_FULL;
      end else begin
         delay_ff <= delay_in;
         fb_ff    <= fb_in;
         wet_ff   <= wet_in;
         dry_ff   <= dry_in;
      end
   end

   // read address behind the write pointer, with wrap
   logic [AW-1:0]  wp_ff;
   logic [AW-1:0]  wp_in;
   logic           wrapped_ff;
   logic           wrapped_in;
   logic [AW:0]    rd_diff;
   logic [AW:0]    rd_wrap;
   logic           rd_borrow;
   logic [AW-1:0]  rd_addr;
   logic           rd_written;

   assign rd_diff    = {1'b0, wp_ff} - {1'b0, delay_ff};
   assign rd_wrap    = {1'b0, wp_ff} + (AW+1)'(STORE_DEPTH) - {1'b0, delay_ff};
   assign rd_borrow  = rd_diff[AW];
   assign rd_addr    = rd_borrow ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
   // entry holds a real sample once the pointer has passed it
   assign rd_written = wrapped_ff || (!rd_borrow && (delay_ff != '0));

   // acceptance: room in the queue for every word in flight, and no read of
   // an entry whose value is still one stage from being written
   logic              s1_valid_ff;
   sample_type        s1_x_ff;
   logic [AW-1:0]     s1_wp_ff;
   logic [AW-1:0]     s1_rd_ff;
   logic              s1_written_ff;
   logic              s2_valid;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W-1:0] occupancy;
   logic              hazard;
   logic              accept;

   assign occupancy  = q_count + QCNT_W'(s1_valid_ff) + QCNT_W'(s2_valid);
   assign hazard     = s1_valid_ff && (rd_addr == s1_wp_ff);
   assign req_tready = (occupancy < QCNT_W'(QUEUE_DEPTH)) && !hazard;
   assign accept     = req_tvalid && req_tready;

   // write pointer and wrap flag
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         if (wp_ff == LAST_ADDR) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         wrapped_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         wrapped_ff  <= wrapped_in;
         s1_valid_ff <= accept;
      end
      s1_x_ff       <= req_tdata;
      s1_wp_ff      <= wp_ff;
      s1_rd_ff      <= rd_addr;
      s1_written_ff <= rd_written;
   end

   // delay store
   sample_type    rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   sample_type    wr_data;

   fdm_store #(
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // feedback and mix arithmetic
   rsp_type rsp;

   fdm_mac #(
      .AW (AW)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid_ff),
      .s1_x       (s1_x_ff),
      .s1_wp      (s1_wp_ff),
      .s1_rd      (s1_rd_ff),
      .s1_written (s1_written_ff),
      .rd_data    (rd_data),
      .fb_gain    (fb_ff),
      .wet_gain   (wet_ff),
      .dry_gain   (dry_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp        (rsp),
      .s2_valid   (s2_valid)
   );

   // result queue
   fdm_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .count      (q_count)
   );

endmodule
`default_nettype wire
